[rtl/bfla_pkg.sv]
// Shared types and codes for the bucket free-list allocator.
`timescale 1ns / 1ps

package bfla_pkg;

   localparam int ADDR_W = 48;
   localparam int SIZE_W = 32;
   localparam int CNT_W = 32;
   localparam int HDR_W = 13;

   localparam int DEF_MAX_BLOCKS = 8192;
   localparam int DEF_MAX_PIECES = 65536;
   localparam int DEF_MAX_LISTS = 256;

   localparam logic [3:0] ALIGN_MASK = 4'hF;

   localparam logic [2:0] ACT_LEND    = 3'd0;
   localparam logic [2:0] ACT_CARVE   = 3'd1;
   localparam logic [2:0] ACT_FILE    = 3'd2;
   localparam logic [2:0] ACT_REISSUE = 3'd3;
   localparam logic [2:0] ACT_RETURN  = 3'd4;

   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_BLK_FULL    = 4'd1;
   localparam logic [3:0] ST_MALFORMED   = 4'd2;
   localparam logic [3:0] ST_UNKNOWN_BLK = 4'd3;
   localparam logic [3:0] ST_BAD_SIZE    = 4'd4;
   localparam logic [3:0] ST_PC_FULL     = 4'd5;
   localparam logic [3:0] ST_UNKNOWN_PC  = 4'd6;
   localparam logic [3:0] ST_FILED       = 4'd7;
   localparam logic [3:0] ST_LS_FULL     = 4'd8;
   localparam logic [3:0] ST_LS_EMPTY    = 4'd9;

   typedef struct packed {
      logic [2:0]        action;
      logic [ADDR_W-1:0] block_address;
      logic [ADDR_W-1:0] block_end;
      logic [SIZE_W-1:0] carve_size;
      logic [ADDR_W-1:0] piece_address;
      logic [ADDR_W-1:0] list_key;
   } req_type;

   typedef struct packed {
      logic [3:0]        status;
      logic [ADDR_W-1:0] result_address;
      logic [ADDR_W-1:0] result_block;
      logic [ADDR_W-1:0] cursor_after;
      logic [CNT_W-1:0]  pieces_carved;
      logic [CNT_W-1:0]  pieces_reissued;
      logic [CNT_W-1:0]  pieces_filed;
   } rsp_type;

   typedef struct packed {
      logic              live;
      logic [ADDR_W-1:0] limit;
      logic [ADDR_W-1:0] cursor;
      logic [ADDR_W-1:0] addr;
   } blk_ent_type;

endpackage

[rtl/bfla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bucket_free_list_allocator.sv]
// Top level: block/piece allocator with address-keyed LIFO free lists.
// One command at a time; each table entry visited is a RAM read, then a check.
// Carve/return: block search over live entries, newest first; return then sweeps every piece,
// then every list chain. File: piece search plus list search; reissue: list search only.
// A finished result sits in an output register; the next command is taken meanwhile.
// Synchronous active-high reset empties all tables and counters; no clearing pass.
`timescale 1ns / 1ps

module bucket_free_list_allocator import bfla_pkg::*; #(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
   parameter int MAX_PIECES = DEF_MAX_PIECES,
   parameter int MAX_LISTS  = DEF_MAX_LISTS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [HDR_W-1:0] csr_data
);

   localparam int BIW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int BCW = $clog2(MAX_BLOCKS + 1);
   localparam int PIW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
   localparam int PCW = $clog2(MAX_PIECES + 1);
   localparam int LIW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
   localparam int LCW = $clog2(MAX_LISTS + 1);
   localparam logic [PCW-1:0] NO_LINK = PCW'(MAX_PIECES);

   typedef struct packed {
      logic              filed;
      logic              live;
      logic [PCW-1:0]    link;
      logic [BIW-1:0]    owner;
      logic [ADDR_W-1:0] addr;
   } pc_ent_type;

   typedef struct packed {
      logic [PCW-1:0]    head;
      logic [ADDR_W-1:0] key;
   } ls_ent_type;

   typedef enum logic [4:0] {
      S_IDLE, S_LEND, S_BSCAN, S_BCHK, S_CARVE, S_PSCAN, S_PCHK, S_LSCAN, S_LCHK,
      S_LFOUND, S_RPIECE, S_RBLK, S_KSCAN, S_KCHK, S_LNEXT, S_LHEAD, S_WALK, S_WCHK,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [HDR_W-1:0]  hdr_ff, hdr_in;
   req_type           req_ff, req_in;
   logic [BCW-1:0]    blk_used_ff, blk_used_in;
   logic [PCW-1:0]    pc_used_ff, pc_used_in;
   logic [LCW-1:0]    ls_used_ff, ls_used_in;
   logic [CNT_W-1:0]  cnt_carve_ff, cnt_carve_in;
   logic [CNT_W-1:0]  cnt_reissue_ff, cnt_reissue_in;
   logic [CNT_W-1:0]  cnt_file_ff, cnt_file_in;
   logic [BCW-1:0]    bidx_ff, bidx_in;
   logic [PCW-1:0]    pidx_ff, pidx_in;
   logic [LCW-1:0]    lidx_ff, lidx_in;
   blk_ent_type       blk_ent_ff, blk_ent_in;
   logic [BIW-1:0]    b_ff, b_in;
   pc_ent_type        pc_ent_ff, pc_ent_in;
   logic [PIW-1:0]    p_ff, p_in;
   logic [PCW-1:0]    ls_head_ff, ls_head_in;
   logic [LIW-1:0]    l_ff, l_in;
   logic [PCW-1:0]    cur_ff, cur_in;
   logic [PIW-1:0]    prev_ff, prev_in;
   pc_ent_type        prev_ent_ff, prev_ent_in;
   logic              prev_head_ff, prev_head_in;
   logic [ADDR_W-1:0] key_ff, key_in;
   logic [3:0]        res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [ADDR_W-1:0] res_block_ff, res_block_in;
   logic [ADDR_W-1:0] res_cafter_ff, res_cafter_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              blk_wr_en, blk_rd_en;
   logic [BIW-1:0]    blk_wr_addr, blk_rd_addr;
   blk_ent_type       blk_wr_data, blk_rd;
   logic [$bits(blk_ent_type)-1:0] blk_rd_data;
   logic              pc_wr_en, pc_rd_en;
   logic [PIW-1:0]    pc_wr_addr, pc_rd_addr;
   pc_ent_type        pc_wr_data, pc_rd;
   logic [$bits(pc_ent_type)-1:0] pc_rd_data;
   logic              ls_wr_en, ls_rd_en;
   logic [LIW-1:0]    ls_wr_addr, ls_rd_addr;
   ls_ent_type        ls_wr_data, ls_rd;
   logic [$bits(ls_ent_type)-1:0] ls_rd_data;

   logic [BCW-1:0]    bidx_dec;
   logic [PCW-1:0]    pidx_dec;
   logic [ADDR_W:0]   lend_cursor;
   logic [ADDR_W-1:0] room;
   logic [ADDR_W-1:0] size_ext;
   logic              size_bad;

   assign blk_rd = blk_ent_type'(blk_rd_data);
   assign pc_rd = pc_ent_type'(pc_rd_data);
   assign ls_rd = ls_ent_type'(ls_rd_data);

   assign bidx_dec = bidx_ff - 1'b1;
   assign pidx_dec = pidx_ff - 1'b1;
   assign lend_cursor = {1'b0, req_ff.block_address} + (ADDR_W + 1)'(hdr_ff);
   assign room = blk_ent_ff.limit - blk_ent_ff.cursor;
   assign size_ext = ADDR_W'(req_ff.carve_size);
   assign size_bad = (req_ff.carve_size == '0) || ((req_ff.carve_size[3:0] & ALIGN_MASK) != '0)
                     || (size_ext > room);

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      hdr_in = csr_valid ? csr_data : hdr_ff;
      req_in = req_ff;
      blk_used_in = blk_used_ff;
      pc_used_in = pc_used_ff;
      ls_used_in = ls_used_ff;
      cnt_carve_in = cnt_carve_ff;
      cnt_reissue_in = cnt_reissue_ff;
      cnt_file_in = cnt_file_ff;
      bidx_in = bidx_ff;
      pidx_in = pidx_ff;
      lidx_in = lidx_ff;
      blk_ent_in = blk_ent_ff;
      b_in = b_ff;
      pc_ent_in = pc_ent_ff;
      p_in = p_ff;
      ls_head_in = ls_head_ff;
      l_in = l_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      prev_ent_in = prev_ent_ff;
      prev_head_in = prev_head_ff;
      key_in = key_ff;
      res_status_in = res_status_ff;
      res_addr_in = res_addr_ff;
      res_block_in = res_block_ff;
      res_cafter_in = res_cafter_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      blk_wr_en = 1'b0;
      blk_wr_addr = '0;
      blk_wr_data = '0;
      blk_rd_en = 1'b0;
      blk_rd_addr = '0;
      pc_wr_en = 1'b0;
      pc_wr_addr = '0;
      pc_wr_data = '0;
      pc_rd_en = 1'b0;
      pc_rd_addr = '0;
      ls_wr_en = 1'b0;
      ls_wr_addr = '0;
      ls_wr_data = '0;
      ls_rd_en = 1'b0;
      ls_rd_addr = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_status_in = ST_OK;
               res_addr_in = '0;
               res_block_in = '0;
               res_cafter_in = '0;
               case (req_data.action)
                  ACT_LEND: state_in = S_LEND;
                  ACT_CARVE, ACT_RETURN: begin
                     bidx_in = blk_used_ff;
                     state_in = S_BSCAN;
                  end
                  ACT_FILE: begin
                     pidx_in = pc_used_ff;
                     state_in = S_PSCAN;
                  end
                  ACT_REISSUE: begin
                     lidx_in = '0;
                     state_in = S_LSCAN;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_LEND: begin
            state_in = S_DONE;
            if (blk_used_ff == BCW'(MAX_BLOCKS)) begin
               res_status_in = ST_BLK_FULL;
            end else if (lend_cursor[ADDR_W] || (req_ff.block_end <= lend_cursor[ADDR_W-1:0]))
            begin
               res_status_in = ST_MALFORMED;
            end else begin
               blk_wr_en = 1'b1;
               blk_wr_addr = blk_used_ff[BIW-1:0];
               blk_wr_data = '{live: 1'b1, limit: req_ff.block_end,
                               cursor: lend_cursor[ADDR_W-1:0], addr: req_ff.block_address};
               blk_used_in = blk_used_ff + 1'b1;
               res_addr_in = req_ff.block_address;
            end
         end
         S_BSCAN: begin
            if (bidx_ff == '0) begin
               res_status_in = ST_UNKNOWN_BLK;
               state_in = S_DONE;
            end else begin
               bidx_in = bidx_dec;
               blk_rd_en = 1'b1;
               blk_rd_addr = bidx_dec[BIW-1:0];
               state_in = S_BCHK;
            end
         end
         S_BCHK: begin
            if (blk_rd.live && (blk_rd.addr == req_ff.block_address)) begin
               blk_ent_in = blk_rd;
               b_in = bidx_ff[BIW-1:0];
               if (req_ff.action == ACT_CARVE) begin
                  state_in = S_CARVE;
               end else begin
                  blk_wr_en = 1'b1;
                  blk_wr_addr = bidx_ff[BIW-1:0];
                  blk_wr_data = blk_rd;
                  blk_wr_data.live = 1'b0;
                  pidx_in = '0;
                  state_in = S_KSCAN;
               end
            end else begin
               state_in = S_BSCAN;
            end
         end
         S_CARVE: begin
            state_in = S_DONE;
            if (size_bad) begin
               res_status_in = ST_BAD_SIZE;
            end else if (pc_used_ff == NO_LINK) begin
               res_status_in = ST_PC_FULL;
            end else begin
               pc_wr_en = 1'b1;
               pc_wr_addr = pc_used_ff[PIW-1:0];
               pc_wr_data = '{filed: 1'b0, live: 1'b1, link: NO_LINK, owner: b_ff,
                              addr: blk_ent_ff.cursor};
               pc_used_in = pc_used_ff + 1'b1;
               blk_wr_en = 1'b1;
               blk_wr_addr = b_ff;
               blk_wr_data = blk_ent_ff;
               blk_wr_data.cursor = blk_ent_ff.cursor + size_ext;
               res_addr_in = blk_ent_ff.cursor;
               res_cafter_in = blk_ent_ff.cursor + size_ext;
               cnt_carve_in = (cnt_carve_ff == '1) ? cnt_carve_ff : cnt_carve_ff + 1'b1;
            end
         end
         S_PSCAN: begin
            if (pidx_ff == '0) begin
               res_status_in = ST_UNKNOWN_PC;
               state_in = S_DONE;
            end else begin
               pidx_in = pidx_dec;
               pc_rd_en = 1'b1;
               pc_rd_addr = pidx_dec[PIW-1:0];
               state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (pc_rd.live && (pc_rd.addr == req_ff.piece_address)) begin
               pc_ent_in = pc_rd;
               p_in = pidx_ff[PIW-1:0];
               if (pc_rd.filed) begin
                  res_status_in = ST_FILED;
                  state_in = S_DONE;
               end else begin
                  lidx_in = '0;
                  state_in = S_LSCAN;
               end
            end else begin
               state_in = S_PSCAN;
            end
         end
         S_LSCAN: begin
            if (lidx_ff == ls_used_ff) begin
               if (ls_used_ff == LCW'(MAX_LISTS)) begin
                  res_status_in = ST_LS_FULL;
                  state_in = S_DONE;
               end else begin
                  ls_wr_en = 1'b1;
                  ls_wr_addr = ls_used_ff[LIW-1:0];
                  ls_wr_data = '{head: NO_LINK, key: req_ff.list_key};
                  ls_used_in = ls_used_ff + 1'b1;
                  l_in = ls_used_ff[LIW-1:0];
                  ls_head_in = NO_LINK;
                  state_in = S_LFOUND;
               end
            end else begin
               ls_rd_en = 1'b1;
               ls_rd_addr = lidx_ff[LIW-1:0];
               state_in = S_LCHK;
            end
         end
         S_LCHK: begin
            if (ls_rd.key == req_ff.list_key) begin
               ls_head_in = ls_rd.head;
               l_in = lidx_ff[LIW-1:0];
               state_in = S_LFOUND;
            end else begin
               lidx_in = lidx_ff + 1'b1;
               state_in = S_LSCAN;
            end
         end
         S_LFOUND: begin
            if (req_ff.action == ACT_FILE) begin
               pc_wr_en = 1'b1;
               pc_wr_addr = p_ff;
               pc_wr_data = pc_ent_ff;
               pc_wr_data.filed = 1'b1;
               pc_wr_data.link = ls_head_ff;
               ls_wr_en = 1'b1;
               ls_wr_addr = l_ff;
               ls_wr_data = '{head: PCW'(p_ff), key: req_ff.list_key};
               cnt_file_in = (cnt_file_ff == '1) ? cnt_file_ff : cnt_file_ff + 1'b1;
               state_in = S_DONE;
            end else if (ls_head_ff >= NO_LINK) begin
               res_status_in = ST_LS_EMPTY;
               state_in = S_DONE;
            end else begin
               pc_rd_en = 1'b1;
               pc_rd_addr = ls_head_ff[PIW-1:0];
               state_in = S_RPIECE;
            end
         end
         S_RPIECE: begin
            ls_wr_en = 1'b1;
            ls_wr_addr = l_ff;
            ls_wr_data = '{head: pc_rd.link, key: req_ff.list_key};
            pc_wr_en = 1'b1;
            pc_wr_addr = ls_head_ff[PIW-1:0];
            pc_wr_data = pc_rd;
            pc_wr_data.link = NO_LINK;
            pc_wr_data.filed = 1'b0;
            res_addr_in = pc_rd.addr;
            blk_rd_en = 1'b1;
            blk_rd_addr = pc_rd.owner;
            state_in = S_RBLK;
         end
         S_RBLK: begin
            res_block_in = blk_rd.addr;
            cnt_reissue_in = (cnt_reissue_ff == '1) ? cnt_reissue_ff : cnt_reissue_ff + 1'b1;
            state_in = S_DONE;
         end
         S_KSCAN: begin
            if (pidx_ff == pc_used_ff) begin
               lidx_in = '0;
               state_in = S_LNEXT;
            end else begin
               pc_rd_en = 1'b1;
               pc_rd_addr = pidx_ff[PIW-1:0];
               state_in = S_KCHK;
            end
         end
         S_KCHK: begin
            if (pc_rd.live && (pc_rd.owner == b_ff)) begin
               pc_wr_en = 1'b1;
               pc_wr_addr = pidx_ff[PIW-1:0];
               pc_wr_data = pc_rd;
               pc_wr_data.live = 1'b0;
            end
            pidx_in = pidx_ff + 1'b1;
            state_in = S_KSCAN;
         end
         S_LNEXT: begin
            if (lidx_ff == ls_used_ff) begin
               state_in = S_DONE;
            end else begin
               ls_rd_en = 1'b1;
               ls_rd_addr = lidx_ff[LIW-1:0];
               state_in = S_LHEAD;
            end
         end
         S_LHEAD: begin
            key_in = ls_rd.key;
            cur_in = ls_rd.head;
            prev_head_in = 1'b1;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (cur_ff >= NO_LINK) begin
               lidx_in = lidx_ff + 1'b1;
               state_in = S_LNEXT;
            end else begin
               pc_rd_en = 1'b1;
               pc_rd_addr = cur_ff[PIW-1:0];
               state_in = S_WCHK;
            end
         end
         S_WCHK: begin
            cur_in = pc_rd.link;
            if (!pc_rd.live) begin
               // unlink the dead piece from whatever points at it
               if (prev_head_ff) begin
                  ls_wr_en = 1'b1;
                  ls_wr_addr = lidx_ff[LIW-1:0];
                  ls_wr_data = '{head: pc_rd.link, key: key_ff};
               end else begin
                  prev_ent_in.link = pc_rd.link;
                  pc_wr_en = 1'b1;
                  pc_wr_addr = prev_ff;
                  pc_wr_data = prev_ent_ff;
                  pc_wr_data.link = pc_rd.link;
               end
            end else begin
               prev_in = cur_ff[PIW-1:0];
               prev_ent_in = pc_rd;
               prev_head_in = 1'b0;
            end
            state_in = S_WALK;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in = '{status: res_status_ff, result_address: res_addr_ff,
                          result_block: res_block_ff, cursor_after: res_cafter_ff,
                          pieces_carved: cnt_carve_in, pieces_reissued: cnt_reissue_in,
                          pieces_filed: cnt_file_in};
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hdr_ff <= HDR_W'(48);
         blk_used_ff <= '0;
         pc_used_ff <= '0;
         ls_used_ff <= '0;
         cnt_carve_ff <= '0;
         cnt_reissue_ff <= '0;
         cnt_file_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hdr_ff <= hdr_in;
         blk_used_ff <= blk_used_in;
         pc_used_ff <= pc_used_in;
         ls_used_ff <= ls_used_in;
         cnt_carve_ff <= cnt_carve_in;
         cnt_reissue_ff <= cnt_reissue_in;
         cnt_file_ff <= cnt_file_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      bidx_ff <= bidx_in;
      pidx_ff <= pidx_in;
      lidx_ff <= lidx_in;
      blk_ent_ff <= blk_ent_in;
      b_ff <= b_in;
      pc_ent_ff <= pc_ent_in;
      p_ff <= p_in;
      ls_head_ff <= ls_head_in;
      l_ff <= l_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      prev_ent_ff <= prev_ent_in;
      prev_head_ff <= prev_head_in;
      key_ff <= key_in;
      res_status_ff <= res_status_in;
      res_addr_ff <= res_addr_in;
      res_block_ff <= res_block_in;
      res_cafter_ff <= res_cafter_in;
      rsp_ff <= rsp_in;
   end

   bfla_ram #(.WIDTH($bits(blk_ent_type)), .DEPTH(MAX_BLOCKS)) u_blk_ram (
      .clock   (clock),
      .wr_en   (blk_wr_en),
      .wr_addr (blk_wr_addr),
      .wr_data (blk_wr_data),
      .rd_en   (blk_rd_en),
      .rd_addr (blk_rd_addr),
      .rd_data (blk_rd_data)
   );

   bfla_ram #(.WIDTH($bits(pc_ent_type)), .DEPTH(MAX_PIECES)) u_pc_ram (
      .clock   (clock),
      .wr_en   (pc_wr_en),
      .wr_addr (pc_wr_addr),
      .wr_data (pc_wr_data),
      .rd_en   (pc_rd_en),
      .rd_addr (pc_rd_addr),
      .rd_data (pc_rd_data)
   );

   bfla_ram #(.WIDTH($bits(ls_ent_type)), .DEPTH(MAX_LISTS)) u_ls_ram (
      .clock   (clock),
      .wr_en   (ls_wr_en),
      .wr_addr (ls_wr_addr),
      .wr_data (ls_wr_data),
      .rd_en   (ls_rd_en),
      .rd_addr (ls_rd_addr),
      .rd_data (ls_rd_data)
   );

endmodule

[rtl/bfla_checker.sv]
// Port-level assertions for the allocator, bound to the top level.
`timescale 1ns / 1ps

module bfla_checker import bfla_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsp_type          rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transfer dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while a command is in flight");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_LS_EMPTY)
      else $error("status code out of range");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.result_address == '0 && rsp_data.cursor_after == '0)
      else $error("address fields set on failed command");

   a_cnt_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid |->
         rsp_data.pieces_carved >= $past(rsp_data.pieces_carved) &&
         rsp_data.pieces_reissued >= $past(rsp_data.pieces_reissued) &&
         rsp_data.pieces_filed >= $past(rsp_data.pieces_filed))
      else $error("counter went backwards");

endmodule

bind bucket_free_list_allocator bfla_checker u_bfla_checker (.*);
